// ===== hdl/lspf_pkg.sv =====
// ----------------------------------------------------------------------------
// lspf_pkg: shared types and constants for the LED stream packet framer
// Byte codes, field widths, register indexes and the packet descriptor.
// ----------------------------------------------------------------------------
package lspf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LED_W      = 13;
  localparam int unsigned PAY_W      = 11;
  localparam int unsigned FRAME_W    = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h9C;
  localparam logic [BYTE_W-1:0] TYPE_BYTE  = 8'hDA;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h36;

  localparam logic [PAY_W-1:0] PAYLOAD_RESET = 11'd170;
  localparam logic [PAY_W-1:0] PAYLOAD_LIMIT = 11'd1500;
  localparam logic [LED_W-1:0] LED_LIMIT     = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;

  // result slots of one item, in emit order
  localparam logic [2:0] SLOT_START = 3'd0;
  localparam logic [2:0] SLOT_TYPE  = 3'd1;
  localparam logic [2:0] SLOT_LEN_H = 3'd2;
  localparam logic [2:0] SLOT_LEN_L = 3'd3;
  localparam logic [2:0] SLOT_NUM   = 3'd4;
  localparam logic [2:0] SLOT_TOTAL = 3'd5;
  localparam logic [2:0] SLOT_DATA  = 3'd6;
  localparam logic [2:0] SLOT_END   = 3'd7;

  // everything the serializer needs to emit the results of one item
  typedef struct packed {
    logic              hdr;
    logic [PAY_W-1:0]  len;
    logic [BYTE_W-1:0] pkt_num;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] data;
    logic              pkt_end;
  } desc_t;

endpackage

// ===== hdl/lspf_ifs.sv =====
// ----------------------------------------------------------------------------
// lspf_ifs: valid/ready channels of the LED stream packet framer
// Input byte stream, output packet stream and the configuration write port.
// ----------------------------------------------------------------------------
interface lspf_in_if;
  import lspf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface lspf_out_if;
  import lspf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              packet_end;
  logic              last;

  modport source (output valid, output out_byte, output packet_end, output last,
                  input ready);
  modport sink (input valid, input out_byte, input packet_end, input last,
                output ready);
endinterface

interface lspf_cfg_if;
  import lspf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/led_stream_packet_framer.sv =====
// ----------------------------------------------------------------------------
// led_stream_packet_framer: frames an LED colour byte stream into packets
// Header (start, type, length, number, count), data bytes and end byte.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  in_if    sink       data_byte
//  out_if   source     out_byte, packet_end, last
//  cfg_if   sink       index, data (0: led_count, 1: max_payload)
//
//  An item waits in the input register, then its 1, 2, 7 or 8 results
//  leave the result register one per cycle while out_if is ready; the
//  output serializer sets the rate, with the next item loaded as the
//  last result is taken. A configuration write starts a packet count
//  division; in_if ready stays low meanwhile. Reset: led_count 0,
//  max_payload 170, frame position 0, packet number 1. Either side may stall at any cycle.
// ----------------------------------------------------------------------------
module led_stream_packet_framer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lspf_in_if.sink    in_if,
  lspf_out_if.source out_if,
  lspf_cfg_if.sink   cfg_if
);
  import lspf_pkg::*;

  logic [FRAME_W-1:0] frame_q, frame_new, div_num;
  logic [PAY_W-1:0]   pay_q, pay_new, pay_raw;
  logic [LED_W-1:0]   leds;
  logic               div_start_q, div_busy, busy, cfg_fire;
  logic [BYTE_W-1:0]  total;
  desc_t              desc;
  logic               desc_valid, desc_ready;

  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;

  assign leds      = (cfg_if.data > LED_LIMIT) ? LED_LIMIT : cfg_if.data;
  assign frame_new = {1'b0, leds} + {leds, 1'b0};
  assign pay_raw   = cfg_if.data[PAY_W-1:0];
  assign pay_new   = (pay_raw == '0) ? PAY_W'(1)
                   : ((pay_raw > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : pay_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      pay_q       <= PAYLOAD_RESET;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= cfg_fire;
      if (cfg_fire && (cfg_if.index == REG_LED_COUNT)) begin
        frame_q <= frame_new;
      end
      if (cfg_fire && (cfg_if.index == REG_MAX_PAYLOAD)) begin
        pay_q <= pay_new;
      end
    end
  end

  // ceil(frame / payload) as floor((frame + payload - 1) / payload)
  assign div_num = frame_q + {{(FRAME_W-PAY_W){1'b0}}, pay_q} - FRAME_W'(1);
  assign busy    = div_start_q || div_busy;

  lspf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num),
    .den_i   (pay_q),
    .busy_o  (div_busy),
    .total_o (total)
  );

  lspf_frm u_frm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .frame_i      (frame_q),
    .payload_i    (pay_q),
    .total_i      (total),
    .busy_i       (busy),
    .desc_o       (desc),
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready)
  );

  lspf_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .out_if       (out_if)
  );

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_if.ready)
    else $error("input accepted while packet count division runs");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.packet_end) |->
      (out_if.last && (out_if.out_byte == END_BYTE)))
    else $error("end byte not flagged as final result");

  a_payload_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pay_q != '0) && (pay_q <= PAYLOAD_LIMIT))
    else $error("max payload register out of range");

  a_cfg_restarts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> busy)
    else $error("configuration write did not start the divider");

endmodule

// ===== hdl/lspf_div.sv =====
// ----------------------------------------------------------------------------
// lspf_div: packet count divider
// Restoring divider, one quotient bit per cycle; keeps the low byte.
// ----------------------------------------------------------------------------
module lspf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lspf_pkg::FRAME_W-1:0]  num_i,
  input  logic [lspf_pkg::PAY_W-1:0]    den_i,
  output logic                          busy_o,
  output logic [lspf_pkg::BYTE_W-1:0]   total_o
);
  import lspf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_W);

  logic               run_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [FRAME_W-1:0] quo_q, quo_d;
  logic [PAY_W-1:0]   rem_q, rem_d;
  logic [PAY_W-1:0]   den_q;
  logic [BYTE_W-1:0]  total_q;
  logic [PAY_W:0]     rem_sh, diff;
  logic               ge;

  assign rem_sh = {rem_q, quo_q[FRAME_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};
  assign rem_d  = ge ? diff[PAY_W-1:0] : rem_sh[PAY_W-1:0];
  assign quo_d  = {quo_q[FRAME_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cnt_q   <= '0;
      total_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(FRAME_W - 1)) begin
        run_q   <= 1'b0;
        total_q <= quo_d[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o  = run_q;
  assign total_o = total_q;

endmodule

// ===== hdl/lspf_frm.sv =====
// ----------------------------------------------------------------------------
// lspf_frm: input register and frame/packet position tracking
// Turns each accepted byte into a descriptor of the results it causes.
// ----------------------------------------------------------------------------
module lspf_frm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lspf_in_if.sink                      in_if,
  input  logic [lspf_pkg::FRAME_W-1:0] frame_i,
  input  logic [lspf_pkg::PAY_W-1:0]   payload_i,
  input  logic [lspf_pkg::BYTE_W-1:0]  total_i,
  input  logic                         busy_i,
  output lspf_pkg::desc_t              desc_o,
  output logic                         desc_valid_o,
  input  logic                         desc_ready_i
);
  import lspf_pkg::*;

  logic               valid_q;
  logic [BYTE_W-1:0]  data_q;
  logic [FRAME_W-1:0] fidx_q, fidx_d;
  logic [PAY_W-1:0]   poff_q, poff_d;
  logic [BYTE_W-1:0]  pnum_q, pnum_d;
  logic [PAY_W-1:0]   clen_q, clen_d;

  logic               empty_frame, restart, hdr, fend, pend, move, in_fire;
  logic [FRAME_W-1:0] fi, fi1, remain;
  logic [PAY_W-1:0]   po, po1, len, cl;
  logic [BYTE_W-1:0]  pn;

  assign empty_frame = (frame_i == '0);
  // frame shrunk under us: start over
  assign restart = (fidx_q >= frame_i);
  assign fi      = restart ? '0 : fidx_q;
  assign po      = restart ? '0 : poff_q;
  assign pn      = restart ? BYTE_W'(1) : pnum_q;
  assign hdr     = (po == '0);
  assign remain  = frame_i - fi;
  assign len     = (remain > {{(FRAME_W-PAY_W){1'b0}}, payload_i})
                 ? payload_i : remain[PAY_W-1:0];
  assign cl      = hdr ? len : clen_q;
  assign fi1     = fi + FRAME_W'(1);
  assign po1     = po + PAY_W'(1);
  assign fend    = (fi1 >= frame_i);
  assign pend    = fend || (po1 >= cl);

  assign fidx_d = fend ? '0 : fi1;
  assign poff_d = pend ? '0 : po1;
  assign pnum_d = fend ? BYTE_W'(1) : (hdr ? pn + BYTE_W'(1) : pn);
  assign clen_d = cl;

  assign desc_valid_o = valid_q && !empty_frame;
  // items of an empty frame are dropped
  assign move    = valid_q && (empty_frame || desc_ready_i);
  assign in_fire = in_if.valid && in_if.ready;

  assign in_if.ready = !busy_i && (!valid_q || move);

  assign desc_o.hdr     = hdr;
  assign desc_o.len     = len;
  assign desc_o.pkt_num = pn;
  assign desc_o.total   = total_i;
  assign desc_o.data    = data_q;
  assign desc_o.pkt_end = pend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fidx_q  <= '0;
      poff_q  <= '0;
      pnum_q  <= BYTE_W'(1);
      clen_q  <= '0;
    end else begin
      if (in_fire) begin
        valid_q <= 1'b1;
      end else if (move) begin
        valid_q <= 1'b0;
      end
      if (move && !empty_frame) begin
        fidx_q <= fidx_d;
        poff_q <= poff_d;
        pnum_q <= pnum_d;
        clen_q <= clen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= in_if.data_byte;
    end
  end

endmodule

// ===== hdl/lspf_ser.sv =====
// ----------------------------------------------------------------------------
// lspf_ser: result register and byte serializer
// Emits a descriptor's header (if hdr), data and end (if pkt_end) bytes, one per cycle while out_if is ready.
// ----------------------------------------------------------------------------
module lspf_ser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lspf_pkg::desc_t desc_i,
  input  logic            desc_valid_i,
  output logic            desc_ready_o,
  lspf_out_if.source      out_if
);
  import lspf_pkg::*;

  logic       valid_q;
  logic [2:0] slot_q;
  desc_t      buf_q;
  logic       is_last, out_fire, load;

  assign is_last  = (slot_q == SLOT_END) || ((slot_q == SLOT_DATA) && !buf_q.pkt_end);
  assign out_fire = out_if.valid && out_if.ready;
  // refill in the same cycle the final result leaves
  assign desc_ready_o = !valid_q || (out_fire && is_last);
  assign load         = desc_valid_i && desc_ready_o;

  always_comb begin
    case (slot_q)
      SLOT_START: out_if.out_byte = START_BYTE;
      SLOT_TYPE:  out_if.out_byte = TYPE_BYTE;
      SLOT_LEN_H: out_if.out_byte = {{(2*BYTE_W-PAY_W){1'b0}}, buf_q.len[PAY_W-1:BYTE_W]};
      SLOT_LEN_L: out_if.out_byte = buf_q.len[BYTE_W-1:0];
      SLOT_NUM:   out_if.out_byte = buf_q.pkt_num;
      SLOT_TOTAL: out_if.out_byte = buf_q.total;
      SLOT_DATA:  out_if.out_byte = buf_q.data;
      default:    out_if.out_byte = END_BYTE;
    endcase
  end

  assign out_if.valid      = valid_q;
  assign out_if.packet_end = (slot_q == SLOT_END);
  assign out_if.last       = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= SLOT_START;
    end else if (load) begin
      valid_q <= 1'b1;
      slot_q  <= desc_i.hdr ? SLOT_START : SLOT_DATA;
    end else if (out_fire) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        slot_q <= slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= desc_i;
    end
  end

endmodule
